>>> sv/ole_pkg.sv
// Package for the ordered list engine: sizes, command and status codes, types.
// No dependencies.
`default_nettype none
package ole_pkg;
    localparam int DEPTH = 16;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_POP_HEAD = 2'd1,
        FN_POP_TAIL = 2'd2,
        FN_DELETE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // memory port bundle between controller and storage
    typedef struct packed {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [31:0]   wr_data;
    } mem_req_t;
endpackage
`default_nettype wire

>>> sv/ole_if.sv
// Request and result channel interfaces for the ordered list engine.
// No dependencies.
`default_nettype none
interface ole_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic signed [31:0] value;
    modport source (output valid, func, value, input ready);
    modport sink (input valid, func, value, output ready);
endinterface

interface ole_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] removed_value;
    logic [4:0]  entry_count;
    modport source (output valid, status, removed_value, entry_count, input ready);
    modport sink (input valid, status, removed_value, entry_count, output ready);
endinterface
`default_nettype wire

>>> sv/ordered_list_engine.sv
// Ordered list engine: bounded list of signed 32-bit values in one RAM.
// Append writes at the tail, and any removal on an empty list reports empty without a read;
// pop tail reads the last entry only, while pop head and delete scan every entry, one per
// cycle, and shift later entries up. One request at a time; the next is taken once the
// result is taken or in the cycle it leaves.
// Reset clears the length and control; RAM is not cleared. Depends on ole_pkg, ole_if, ole_store.
`default_nettype none
module ordered_list_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    ole_req_if.sink   req,
    ole_rsp_if.source rsp
);
    localparam int AW = ole_pkg::AW;
    localparam int CW = ole_pkg::CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(ole_pkg::DEPTH);

    ole_pkg::state_t state_reg, state_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] idx_reg, idx_next;     // read position of the scan
    logic          found_reg, found_next; // match seen; now shifting
    logic [31:0]   key_reg, key_next;
    logic [1:0]    func_reg, func_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   rem_reg, rem_next;
    logic          vld_reg, vld_next;
    logic          rd_pend_reg, rd_pend_next;
    ole_pkg::mem_req_t mreq;
    logic [31:0]   rd_data;
    logic          take;

    ole_store u_store (.clk(clk), .req(mreq), .rd_data(rd_data));

    assign take = req.valid && req.ready;
    assign req.ready = (state_reg == ole_pkg::S_IDLE) && (!vld_reg || rsp.ready);
    assign rsp.valid = vld_reg;
    assign rsp.status = st_reg;
    assign rsp.removed_value = rem_reg;
    assign rsp.entry_count = 5'(len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ole_pkg::S_IDLE;
            len_reg <= '0;
            vld_reg <= 1'b0;
            found_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            vld_reg <= vld_next;
            found_reg <= found_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        func_reg <= func_next;
        st_reg <= st_next;
        rem_reg <= rem_next;
    end

    // sequencer: scan reads entry idx; data arrives next cycle as rd_data
    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        key_next = key_reg;
        func_next = func_reg;
        st_next = st_reg;
        rem_next = rem_reg;
        vld_next = vld_reg && !rsp.ready;
        rd_pend_next = 1'b0;
        mreq = '0;
        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (take)
                begin
                    func_next = req.func;
                    key_next = req.value;
                    rem_next = '0;
                    st_next = ole_pkg::ST_OK;
                    found_next = 1'b0;
                    case (ole_pkg::func_t'(req.func))
                        ole_pkg::FN_APPEND:
                        begin
                            if (len_reg >= DEPTH_C)
                            begin
                                st_next = ole_pkg::ST_FULL;
                            end
                            else
                            begin
                                mreq.wr_en = 1'b1;
                                mreq.wr_addr = len_reg[AW-1:0];
                                mreq.wr_data = req.value;
                                len_next = len_reg + 1'b1;
                            end
                            state_next = ole_pkg::S_DONE;
                        end
                        default:
                        begin
                            if (len_reg == '0)
                            begin
                                st_next = ole_pkg::ST_EMPTY;
                                state_next = ole_pkg::S_DONE;
                            end
                            else
                            begin
                                // pop tail reads the last entry only
                                idx_next = (req.func == 2'(ole_pkg::FN_POP_TAIL))
                                           ? len_reg - 1'b1 : '0;
                                mreq.rd_en = 1'b1;
                                mreq.rd_addr = idx_next[AW-1:0];
                                rd_pend_next = 1'b1;
                                state_next = ole_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end
            ole_pkg::S_SCAN:
            begin
                // rd_data holds entry idx_reg
                if (found_reg)
                begin
                    // move entry idx up one place
                    mreq.wr_en = 1'b1;
                    mreq.wr_addr = AW'(idx_reg - 1'b1);
                    mreq.wr_data = rd_data;
                end
                if (!found_reg && (func_reg != 2'(ole_pkg::FN_DELETE)
                                   || rd_data == key_reg))
                begin
                    found_next = 1'b1;
                    rem_next = rd_data;
                end
                if (found_next && func_reg == 2'(ole_pkg::FN_POP_TAIL))
                begin
                    len_next = len_reg - 1'b1;
                    state_next = ole_pkg::S_DONE;
                end
                else if (idx_reg + 1'b1 >= len_reg)
                begin
                    if (found_next)
                    begin
                        len_next = len_reg - 1'b1;
                    end
                    else
                    begin
                        st_next = ole_pkg::ST_NOT_FOUND;
                    end
                    state_next = ole_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    mreq.rd_en = 1'b1;
                    mreq.rd_addr = idx_next[AW-1:0];
                    rd_pend_next = 1'b1;
                end
            end
            ole_pkg::S_DONE:
            begin
                vld_next = 1'b1;
                state_next = ole_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

    // checks on the sequencer
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_C) else $error("length beyond depth");
    a_scan_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ole_pkg::S_SCAN |-> rd_pend_reg) else $error("scan without read");
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ole_pkg::S_DONE |=> vld_reg && state_reg == ole_pkg::S_IDLE)
        else $error("result not posted");
    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ole_pkg::S_IDLE |=> $stable(len_reg) || state_reg == ole_pkg::S_DONE)
        else $error("length changed mid-scan");
endmodule
`default_nettype wire

>>> sv/ole_store.sv
// Entry storage: one synchronous RAM, one write and one read port, registered read.
// Depends on ole_pkg.
`default_nettype none
module ole_store (
    input  wire logic              clk,
    input  wire ole_pkg::mem_req_t req,
    output logic [31:0]            rd_data
);
    logic [31:0] mem [ole_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule
`default_nettype wire
